// ===== design/sai_pkg.sv =====
// Shared constants for the sorted array insert block.
`default_nettype none

package sai_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int CNT_W  = 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;   // register index (paddr[2])
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 8'd100;

    // Default table depth
    localparam int DEPTH_DEFAULT = 128;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

endpackage

`default_nettype wire

// ===== design/sai_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none

module sai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/sai_cfg.sv =====
// APB register file holding the capacity register.
`default_nettype none

module sai_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sai_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sai_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sai_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [sai_pkg::CNT_W-1:0]        capacity
);

    import sai_pkg::*;

    logic [CNT_W-1:0] capacity_reg;
    logic             wr_en;
    logic             sel_cap;

    // Register decode on the word address
    assign sel_cap = (paddr[2] == REG_CAPACITY);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en && sel_cap)
        begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (sel_cap)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

// ===== design/sorted_array_insert_core.sv =====
// Sorted table of signed Q16.16 values with binary search insertion.
// An insert runs a binary search, each probe passing through ST_PROBE and ST_CMP, then
// moves the entries at and above the position up one entry per cycle, then writes the
// value and presents the result through ST_FIN; a clear or a refused insert goes
// straight to ST_FIN. The search probes and the shift share the single read port of the
// table RAM. One item is worked on at a time; in_stall is high from the cycle after an
// item is taken until it finishes, while an unread result may still wait in the output
// register. Capacity values above DEPTH act as the smaller of DEPTH and 255.
`default_nettype none

module sorted_array_insert_core #(
    parameter int DEPTH = sai_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sai_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sai_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [sai_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            action,
    input  wire logic signed [sai_pkg::DATA_W-1:0] value,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 accepted,
    output logic      [sai_pkg::CNT_W-1:0]       position,
    output logic      [sai_pkg::CNT_W-1:0]       count,
    output logic                                 empty_res
);

    import sai_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int DEPTH_CAP = (DEPTH > 255) ? 255 : DEPTH;

    // Unit step for the signed search bounds
    localparam logic signed [CNT_W:0] BOUND_STEP = (CNT_W+1)'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROBE = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [CNT_W-1:0] capacity;
    logic [CNT_W-1:0] cap_eff;

    logic [2:0]              state_reg, state_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [CNT_W:0]   lo_reg, lo_next;
    logic signed [CNT_W:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        wptr_reg, wptr_next;
    logic                    pend_reg, pend_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    res_acc_reg, res_acc_next;
    logic [CNT_W-1:0]        res_pos_reg, res_pos_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_acc_reg, out_acc_next;
    logic [CNT_W-1:0]        out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;

    logic                    in_take;
    logic [CNT_W+1:0]        mid_sum;
    logic [CNT_W-1:0]        mid_w;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DATA_W-1:0]       mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [DATA_W-1:0]       mem_rdata;
    logic signed [DATA_W-1:0] probe;

    sai_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    sai_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Capacity saturates at the table depth, capped at 255
    assign cap_eff = (capacity > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : capacity;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    // Midpoint of the search window (both bounds non-negative while probing)
    assign mid_sum = {lo_reg[CNT_W], lo_reg} + {hi_reg[CNT_W], hi_reg};
    assign mid_w   = mid_sum[CNT_W:1];
    assign probe   = mem_rdata;

    // RAM port steering: search probes and shift reads share the read port
    always_comb
    begin
        mem_raddr = AW'(mid_w);
        if (state_reg == ST_SHIFT)
        begin
            mem_raddr = AW'(i_reg - 1'b1);
        end
        mem_we    = 1'b0;
        mem_waddr = AW'(wptr_reg);
        mem_wdata = mem_rdata;
        if (state_reg == ST_SHIFT)
        begin
            if (pend_reg)
            begin
                mem_we = 1'b1;
            end
            else if (i_reg == idx_reg)
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = val_reg;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        val_next     = val_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        i_next       = i_reg;
        wptr_next    = wptr_reg;
        pend_next    = pend_reg;
        count_next   = count_reg;
        res_acc_next = res_acc_reg;
        res_pos_next = res_pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    val_next     = value;
                    res_pos_next = '0;
                    if (action == ACT_CLEAR)
                    begin
                        count_next   = '0;
                        res_acc_next = 1'b1;
                        state_next   = ST_FIN;
                    end
                    else if (count_reg < cap_eff)
                    begin
                        lo_next    = '0;
                        hi_next    = $signed({1'b0, count_reg}) - BOUND_STEP;
                        idx_next   = '0;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        res_acc_next = 1'b0;
                        state_next   = ST_FIN;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid_w;
                    state_next = ST_CMP;
                end
                else
                begin
                    i_next     = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_CMP:
            begin
                if (probe == val_reg)
                begin
                    idx_next   = mid_reg;
                    i_next     = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    if (val_reg > probe)
                    begin
                        lo_next  = $signed({1'b0, mid_reg}) + BOUND_STEP;
                        idx_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = $signed({1'b0, mid_reg}) - BOUND_STEP;
                    end
                    state_next = ST_PROBE;
                end
            end
            ST_SHIFT:
            begin
                // Move one entry up per cycle: read i-1 now, write it to i next cycle
                if (i_reg > idx_reg)
                begin
                    pend_next = 1'b1;
                    wptr_next = i_reg;
                    i_next    = i_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next   = count_reg + 1'b1;
                        res_acc_next = 1'b1;
                        res_pos_next = idx_reg;
                        state_next   = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_pos_next   = out_pos_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_FIN) && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_acc_next   = res_acc_reg;
            out_pos_next   = res_pos_reg;
            out_cnt_next   = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        i_reg       <= i_next;
        wptr_reg    <= wptr_next;
        res_acc_reg <= res_acc_next;
        res_pos_reg <= res_pos_next;
        out_acc_reg <= out_acc_next;
        out_pos_reg <= out_pos_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_acc_reg;
    assign position  = out_pos_reg;
    assign count     = out_cnt_reg;
    assign empty_res = (out_cnt_reg == '0);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH_CAP))
        else $error("fill count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == '0) || (count_reg == $past(count_reg) + 1'b1)))
        else $error("fill count moved by more than one");

    a_shift_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_reg <= i_reg))
        else $error("shift pointer passed insert position");

    a_refused_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_acc_reg) |-> (out_pos_reg == '0))
        else $error("refused insert reports nonzero position");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SHIFT))
        else $error("table written outside shift phase");

endmodule

`default_nettype wire
